FILE: design/smde_pkg.sv
// Shared types, constants and rounding helpers for the sun and moon ephemeris.
package smde_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int VEC_W        = FRAC_BITS + 6;
    localparam int Z_W          = 34;
    localparam int GAIN_W       = 31;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
    localparam int BACK_DEPTH   = 4 * CORDIC_LAT;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [GAIN_W-1:0] GAIN_Q30   = 31'd652032874;
    localparam logic [20:0]       HOURS_MAX  = 21'd1572864;
    localparam logic [24:0]       DAY_ONE    = 25'd65536;
    localparam logic [19:0]       DIV3_MUL   = 20'd699051;
    localparam int                DIV3_SH    = 21;
    localparam int                INCL_LIMIT = 14603;
    localparam int                ONE        = 1 << FRAC_BITS;

    // Rounding into Q1.14 and into the Q1.16 lit fraction.
    localparam int Q_DN  = (FRAC_BITS > 14) ? FRAC_BITS - 14 : 0;
    localparam int Q_UP  = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam int Q_RND = (FRAC_BITS > 14) ? (1 << (Q_DN - 1)) : 0;
    localparam int L_DN  = (FRAC_BITS > 15) ? FRAC_BITS - 15 : 0;
    localparam int L_UP  = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
    localparam int L_RND = (FRAC_BITS > 15) ? (1 << (L_DN - 1)) : 0;

    localparam logic [2:0] CFG_ROTATION_RATE     = 3'd0;
    localparam logic [2:0] CFG_ORBIT_RATE        = 3'd1;
    localparam logic [2:0] CFG_MOON_RATE         = 3'd2;
    localparam logic [2:0] CFG_EQX_DAY           = 3'd3;
    localparam logic [2:0] CFG_MOON_PHASE_OFFSET = 3'd4;
    localparam logic [2:0] CFG_AXIAL_TILT        = 3'd5;
    localparam logic [2:0] CFG_MOON_INCL         = 3'd6;

    localparam logic [31:0] ATAN_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic signed [VEC_W-1:0] t_vec;

    typedef struct packed {
        logic [31:0] rotation_rate;
        logic [31:0] orbit_rate;
        logic [31:0] moon_rate;
        logic [24:0] eqx_day;
        logic [15:0] moon_phase_offset;
        logic [15:0] axial_tilt;
        logic [15:0] moon_incl;
    } t_cfg;

    // Angles of one timestamp, handed from front to back.
    typedef struct packed {
        logic [24:0] sim;
        logic [31:0] rot_a;
        logic [31:0] orb_a;
        logic [31:0] moon_a;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] sun_x;
        logic signed [15:0] sun_y;
        logic signed [15:0] sun_z;
        logic signed [15:0] moon_x;
        logic signed [15:0] moon_y;
        logic signed [15:0] moon_z;
        logic [15:0]        moon_phase;
        logic [16:0]        moon_lit_fraction;
        logic [24:0]        sim_day;
        logic [15:0]        rotation_turns;
        logic [15:0]        orbit_turns;
        logic [15:0]        moon_orbit_turns;
    } t_result;

    function automatic logic signed [15:0] to_q14(input t_vec v);
        logic signed [VEC_W+1:0] e;
        e = (VEC_W+2)'(v);
        e = ((e + (VEC_W+2)'(Q_RND)) >>> Q_DN) <<< Q_UP;
        if (e > 16384) begin
            e = 16384;
        end else if (e < -16384) begin
            e = -16384;
        end
        return e[15:0];
    endfunction

    function automatic logic [16:0] lit_frac(input t_vec c);
        logic signed [VEC_W+3:0] e;
        e = (VEC_W+4)'(ONE) - (VEC_W+4)'(c);
        e = ((e + (VEC_W+4)'(L_RND)) >>> L_DN) <<< L_UP;
        if (e < 0) begin
            e = 0;
        end else if (e > 65536) begin
            e = 65536;
        end
        return e[16:0];
    endfunction

endpackage

FILE: design/smde_cordic.sv
// Pipelined CORDIC rotation of a vector by an angle in turns, with gain correction.
module smde_cordic (
    input  logic          i_clk,
    input  logic          i_en,
    input  smde_pkg::t_vec i_x,
    input  smde_pkg::t_vec i_y,
    input  logic [31:0]   i_angle,
    output smde_pkg::t_vec o_x,
    output smde_pkg::t_vec o_y
);
    import smde_pkg::*;

    localparam logic signed [GAIN_W:0] GAIN_S = {1'b0, GAIN_Q30};
    localparam int PW = VEC_W + GAIN_W + 1;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< 29;

    t_vec                  r_x [0:CORDIC_STEPS];
    t_vec                  r_y [0:CORDIC_STEPS];
    logic signed [Z_W-1:0] r_z [0:CORDIC_STEPS];
    logic signed [PW-1:0]  r_px, r_py;
    t_vec                  r_ox, r_oy;

    logic        fold;
    logic [31:0] n_t;
    logic [31:0] quarter;

    // Fold the half turn around the negative x axis into the CORDIC range.
    always_comb begin
        quarter = i_angle + 32'h4000_0000;
        fold    = quarter[31];
        n_t     = fold ? (i_angle + 32'h8000_0000) : i_angle;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= fold ? -i_x : i_x;
            r_y[0] <= fold ? -i_y : i_y;
            r_z[0] <= Z_W'($signed(n_t));
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(ATAN_TURNS[k]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][Z_W-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATAN_K;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATAN_K;
                end
            end
        end
    end

    // Scale out the CORDIC gain, then round half up.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= PW'(r_x[CORDIC_STEPS]) * PW'(GAIN_S);
            r_py <= PW'(r_y[CORDIC_STEPS]) * PW'(GAIN_S);
            r_ox <= VEC_W'((r_px + HALF) >>> 30);
            r_oy <= VEC_W'((r_py + HALF) >>> 30);
        end
    end

    assign o_x = r_ox;
    assign o_y = r_oy;

endmodule

FILE: design/smde_front.sv
// Front end: clamps the timestamp, forms the simulation day and the three angles.
module smde_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smde_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [24:0]       i_day_of_year,
    input  logic [20:0]       i_time_hours,
    input  logic              i_full,
    output logic              o_push,
    output smde_pkg::t_angles o_word
);
    import smde_pkg::*;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic [24:0]         r_day1, r_day2;
    logic [20:0]         r_hrs1;
    logic [37:0]         r_prod2;
    logic [24:0]         r_sim3, r_sim4;
    logic signed [25:0]  r_diff3;
    logic [56:0]         r_prodr, r_prodm;
    logic signed [58:0]  r_prodo;

    logic        en;
    logic [24:0] n_sim;

    assign en         = !(r_v4 && i_full);
    assign o_in_stall = !en;
    assign o_push     = r_v4 && !i_full;

    // Quotient of the clamped hours by 24 joins the day part.
    assign n_sim = r_day2 + 25'(r_prod2 >> DIV3_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_day1  <= (i_day_of_year > DAY_ONE) ? (i_day_of_year - DAY_ONE) : 25'd0;
            r_hrs1  <= (i_time_hours > HOURS_MAX) ? HOURS_MAX : i_time_hours;
            r_day2  <= r_day1;
            r_prod2 <= 38'(r_hrs1[20:3]) * 38'(DIV3_MUL);
            r_sim3  <= n_sim;
            r_diff3 <= $signed({1'b0, n_sim}) - $signed({1'b0, i_cfg.eqx_day});
            r_sim4  <= r_sim3;
            r_prodr <= 57'(r_sim3) * 57'(i_cfg.rotation_rate);
            r_prodm <= 57'(r_sim3) * 57'(i_cfg.moon_rate);
            r_prodo <= 59'(r_diff3) * 59'($signed({1'b0, i_cfg.orbit_rate}));
        end
    end

    always_comb begin
        o_word.sim    = r_sim4;
        o_word.rot_a  = r_prodr[39:8];
        o_word.orb_a  = r_prodo[39:8];
        o_word.moon_a = r_prodm[39:8] + {i_cfg.moon_phase_offset, 16'd0};
    end

endmodule

FILE: design/smde_queue.sv
// Short queue of angle words between the front end and the back end.
module smde_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  smde_pkg::t_angles i_word,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output smde_pkg::t_angles o_word
);
    import smde_pkg::*;

    t_angles           r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    logic do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

FILE: design/smde_back.sv
// Back end: chains the CORDIC rotations for sun, moon and phase, and holds the result word.
module smde_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smde_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  smde_pkg::t_angles i_q_word,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output smde_pkg::t_result o_res
);
    import smde_pkg::*;

    localparam int L = CORDIC_LAT;

    typedef struct packed {
        logic [31:0] rot_a;
        logic [24:0] sim;
        logic [15:0] phase;
        logic [31:0] orb_a;
        logic [31:0] moon_a;
        logic [16:0] lit;
        t_vec        sx;
        t_vec        sy;
        t_vec        sz;
        t_vec        mx;
        t_vec        my;
    } t_rec;

    t_rec    r_pipe [0:BACK_DEPTH];
    t_rec    n_pipe [1:BACK_DEPTH];
    logic    r_pv   [0:BACK_DEPTH];
    logic    r_out_valid;
    t_result r_res;

    logic               adv;
    t_rec               n_head;
    logic signed [15:0] incl;
    logic [31:0]        tilt_a, inc_a;
    t_vec               one_v;
    t_vec               c_sun, s_sun, c_moon, s_moon, c_ph;
    t_vec               sy_t, sz_t, my_i, mz_i, sx_r, sz_r, my_t, mz_t, mx_r, mz_r;

    assign adv     = !r_out_valid || !i_out_stall;
    assign o_q_pop = adv && i_q_valid;
    assign one_v   = VEC_W'(ONE);

    // Clamp the inclination to 1.4 rad.
    always_comb begin
        incl = $signed(i_cfg.moon_incl);
        if (incl > 16'(INCL_LIMIT)) begin
            incl = 16'(INCL_LIMIT);
        end else if (incl < -16'(INCL_LIMIT)) begin
            incl = -16'(INCL_LIMIT);
        end
        tilt_a = {i_cfg.axial_tilt, 16'd0};
        inc_a  = {incl, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else if (adv) begin
            r_pv[0] <= o_q_pop;
        end
    end

    always_comb begin
        n_head        = '0;
        n_head.rot_a  = i_q_word.rot_a;
        n_head.sim    = i_q_word.sim;
        n_head.phase  = i_q_word.moon_a[31:16] - i_q_word.orb_a[31:16];
        n_head.orb_a  = i_q_word.orb_a;
        n_head.moon_a = i_q_word.moon_a;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pipe[0] <= n_head;
        end
    end

    // Capture CORDIC results into the record as they line up with it.
    for (genvar k = 0; k < BACK_DEPTH; k++) begin : g_pipe
        always_comb begin
            n_pipe[k+1] = r_pipe[k];
            if (k == L) begin
                n_pipe[k+1].sx  = c_sun;
                n_pipe[k+1].mx  = c_moon;
                n_pipe[k+1].lit = lit_frac(c_ph);
            end
            if (k == 2 * L) begin
                n_pipe[k+1].sy = sy_t;
            end
            if (k == 3 * L) begin
                n_pipe[k+1].sx = sx_r;
                n_pipe[k+1].sz = sz_r;
                n_pipe[k+1].my = my_t;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[k+1] <= 1'b0;
            end else if (adv) begin
                r_pv[k+1] <= r_pv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pipe[k+1] <= n_pipe[k+1];
            end
        end
    end

    // First rank: orbit, moon and phase angles from the unit x vector.
    smde_cordic u_orb (
        .i_clk(i_clk), .i_en(adv), .i_x(one_v), .i_y('0),
        .i_angle(r_pipe[0].orb_a),
        .o_x(c_sun), .o_y(s_sun)
    );

    smde_cordic u_moon (
        .i_clk(i_clk), .i_en(adv), .i_x(one_v), .i_y('0),
        .i_angle(r_pipe[0].moon_a),
        .o_x(c_moon), .o_y(s_moon)
    );

    smde_cordic u_phase (
        .i_clk(i_clk), .i_en(adv), .i_x(one_v), .i_y('0),
        .i_angle({r_pipe[0].phase, 16'd0}),
        .o_x(c_ph), .o_y()
    );

    // Second rank: sun through the tilt, moon through its inclination.
    smde_cordic u_sun_tilt (
        .i_clk(i_clk), .i_en(adv), .i_x('0), .i_y(-s_sun), .i_angle(tilt_a),
        .o_x(sy_t), .o_y(sz_t)
    );

    smde_cordic u_moon_inc (
        .i_clk(i_clk), .i_en(adv), .i_x('0), .i_y(-s_moon), .i_angle(inc_a),
        .o_x(my_i), .o_y(mz_i)
    );

    // Third rank: sun by the rotation angle, moon through the tilt.
    smde_cordic u_sun_rot (
        .i_clk(i_clk), .i_en(adv), .i_x(r_pipe[2*L].sx), .i_y(sz_t),
        .i_angle(r_pipe[2*L].rot_a), .o_x(sx_r), .o_y(sz_r)
    );

    smde_cordic u_moon_tilt (
        .i_clk(i_clk), .i_en(adv), .i_x(my_i), .i_y(mz_i), .i_angle(tilt_a),
        .o_x(my_t), .o_y(mz_t)
    );

    // Fourth rank: moon by the rotation angle.
    smde_cordic u_moon_rot (
        .i_clk(i_clk), .i_en(adv), .i_x(r_pipe[3*L].mx), .i_y(mz_t),
        .i_angle(r_pipe[3*L].rot_a), .o_x(mx_r), .o_y(mz_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_pv[BACK_DEPTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_pv[BACK_DEPTH]) begin
            r_res.sun_x             <= to_q14(r_pipe[BACK_DEPTH].sx);
            r_res.sun_y             <= to_q14(r_pipe[BACK_DEPTH].sy);
            r_res.sun_z             <= to_q14(r_pipe[BACK_DEPTH].sz);
            r_res.moon_x            <= to_q14(mx_r);
            r_res.moon_y            <= to_q14(r_pipe[BACK_DEPTH].my);
            r_res.moon_z            <= to_q14(mz_r);
            r_res.moon_phase        <= r_pipe[BACK_DEPTH].phase;
            r_res.moon_lit_fraction <= r_pipe[BACK_DEPTH].lit;
            r_res.sim_day           <= r_pipe[BACK_DEPTH].sim;
            r_res.rotation_turns    <= r_pipe[BACK_DEPTH].rot_a[31:16];
            r_res.orbit_turns       <= r_pipe[BACK_DEPTH].orb_a[31:16];
            r_res.moon_orbit_turns  <= r_pipe[BACK_DEPTH].moon_a[31:16];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

FILE: design/sun_moon_direction_ephemeris.sv
// Top level of the sun and moon direction ephemeris: register bank, front end, queue, back end.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-------------------------------------
//  in       | in        | i_in_valid / o_in_stall   | i_day_of_year, i_time_hours
//  out      | out       | o_out_valid / i_out_stall | sun, moon vectors, phase, lit, angles
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word is taken per cycle and one result leaves per cycle when nothing stalls.
// A word passes the front-end registers, the queue, four chained CORDIC units and the
// output register; the chained rotations set the depth.
// Reset (i_rst_n low, synchronous) restores the register defaults and empties all stages.
// A stall on the output freezes the back end; the queue absorbs front words until full,
// then the front end freezes and raises o_in_stall.
module sun_moon_direction_ephemeris (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [24:0]        i_day_of_year,
    input  logic [20:0]        i_time_hours,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sun_x,
    output logic signed [15:0] o_sun_y,
    output logic signed [15:0] o_sun_z,
    output logic signed [15:0] o_moon_x,
    output logic signed [15:0] o_moon_y,
    output logic signed [15:0] o_moon_z,
    output logic [15:0]        o_moon_phase,
    output logic [16:0]        o_moon_lit_fraction,
    output logic [24:0]        o_sim_day,
    output logic [15:0]        o_rotation_turns,
    output logic [15:0]        o_orbit_turns,
    output logic [15:0]        o_moon_orbit_turns,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import smde_pkg::*;

    t_cfg    r_cfg;
    logic    full, push, q_valid, pop;
    t_angles f_word, q_word;
    t_result res;

    // Register writes are always taken; unknown indexes drop the data.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation_rate     <= 32'd16777216;
            r_cfg.orbit_rate        <= 32'd45934;
            r_cfg.moon_rate         <= 32'd614102;
            r_cfg.eqx_day           <= 25'd0;
            r_cfg.moon_phase_offset <= 16'd0;
            r_cfg.axial_tilt        <= 16'd0;
            r_cfg.moon_incl         <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROTATION_RATE:     r_cfg.rotation_rate     <= i_cfg_data;
                CFG_ORBIT_RATE:        r_cfg.orbit_rate        <= i_cfg_data;
                CFG_MOON_RATE:         r_cfg.moon_rate         <= i_cfg_data;
                CFG_EQX_DAY:           r_cfg.eqx_day           <= i_cfg_data[24:0];
                CFG_MOON_PHASE_OFFSET: r_cfg.moon_phase_offset <= i_cfg_data[15:0];
                CFG_AXIAL_TILT:        r_cfg.axial_tilt        <= i_cfg_data[15:0];
                CFG_MOON_INCL:         r_cfg.moon_incl         <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    smde_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_day_of_year(i_day_of_year), .i_time_hours(i_time_hours),
        .i_full(full), .o_push(push), .o_word(f_word)
    );

    smde_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(f_word),
        .o_full(full), .i_pop(pop), .o_valid(q_valid), .o_word(q_word)
    );

    smde_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_q_valid(q_valid), .i_q_word(q_word), .o_q_pop(pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_res(res)
    );

    assign o_sun_x             = res.sun_x;
    assign o_sun_y             = res.sun_y;
    assign o_sun_z             = res.sun_z;
    assign o_moon_x            = res.moon_x;
    assign o_moon_y            = res.moon_y;
    assign o_moon_z            = res.moon_z;
    assign o_moon_phase        = res.moon_phase;
    assign o_moon_lit_fraction = res.moon_lit_fraction;
    assign o_sim_day           = res.sim_day;
    assign o_rotation_turns    = res.rotation_turns;
    assign o_orbit_turns       = res.orbit_turns;
    assign o_moon_orbit_turns  = res.moon_orbit_turns;

endmodule
